@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks sampled on clk, switched off while rst is high.
// The module that uses them must have signals named clk and rst.

// Whenever cond holds, expr must hold on the same clock edge.
`define ASSERT_IMPLIES(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Whenever cond holds, expr must hold after the delay given by the delay argument.
`define ASSERT_DELAYED(label, cond, delay, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##(delay) (expr)) \
    else $error(msg);

`endif

@@ hw/rtl/dvbi_pkg.sv @@
package dvbi_pkg;

  // Default sizing of the unit.
  localparam int MAX_SECTORS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 16;
  localparam int DIR_BITS_DEF    = 16;
  localparam int ANGLE_BITS_DEF  = 16;

  // Result field width.
  localparam int VIEW_W = 11;

  // Configuration channel.
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;
  localparam int SECTORS_FIELD_W = 7;
  localparam int ROWS_FIELD_W  = 5;

  localparam int SECTORS_RESET = 8;
  localparam int ROWS_RESET    = 0;
  localparam logic HEMI_RESET  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTORS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_HEMI    = 2'd2
  } cfg_reg_t;

  // Direction components are scaled to 32-bit signed values before the
  // arctangents. After negation and CORDIC gain they stay below 2^33.
  localparam int XY_W  = 35;
  // Angle accumulator in Q32 turns, with room for the half-turn offset.
  localparam int ACC_W = 34;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int SQ_IN_W      = 64;
  localparam int HORIZ_W      = 32;

  // atan(2^-i) in Q32 turns.
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

endpackage

@@ hw/rtl/dvbi_cordic.sv @@
module dvbi_cordic #(
  parameter int TAG_W = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  src_valid,
  input  logic signed [dvbi_pkg::XY_W-1:0]      x0,
  input  logic signed [dvbi_pkg::XY_W-1:0]      y0,
  input  logic signed [dvbi_pkg::ACC_W-1:0]     angle0,
  input  logic [TAG_W-1:0]                      tag,
  output logic                                  angle_valid,
  output logic signed [dvbi_pkg::ACC_W-1:0]     angle,
  output logic [TAG_W-1:0]                      angle_tag
);

  localparam int STEPS = dvbi_pkg::CORDIC_STEPS;

  logic                                 vld   [STEPS+1];
  logic signed [dvbi_pkg::XY_W-1:0]     xs    [STEPS+1];
  logic signed [dvbi_pkg::XY_W-1:0]     ys    [STEPS+1];
  logic signed [dvbi_pkg::ACC_W-1:0]    acc   [STEPS+1];
  logic [TAG_W-1:0]                     tags  [STEPS+1];

  assign vld[0]  = src_valid;
  assign xs[0]   = x0;
  assign ys[0]   = y0;
  assign acc[0]  = angle0;
  assign tags[0] = tag;

  // One micro-rotation per stage. The sign of y picks the direction, zero
  // counting as positive; the shifts are arithmetic (floor).
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [dvbi_pkg::ACC_W-1:0] ATAN =
      $signed(dvbi_pkg::ACC_W'(dvbi_pkg::ATAN_TURNS[i]));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      if (!ys[i][dvbi_pkg::XY_W-1]) begin
        xs[i+1]  <= xs[i] + (ys[i] >>> i);
        ys[i+1]  <= ys[i] - (xs[i] >>> i);
        acc[i+1] <= acc[i] + ATAN;
      end else begin
        xs[i+1]  <= xs[i] - (ys[i] >>> i);
        ys[i+1]  <= ys[i] + (xs[i] >>> i);
        acc[i+1] <= acc[i] - ATAN;
      end
      tags[i+1] <= tags[i];
    end
  end

  assign angle_valid = vld[STEPS];
  assign angle       = acc[STEPS];
  assign angle_tag   = tags[STEPS];

endmodule

@@ hw/rtl/direction_to_view_bin_index_unit.sv @@
// Direction to view bin index.
// Maps a signed direction (dir_x, dir_y, dir_z) to the index of a snapshot
// view laid out as latitude rows times longitude sectors.
// Input: a transaction is taken at a rising edge with start high and busy
// low. busy is high only during reset and in the cycle after it; afterwards one
// direction can be started in every cycle.
// Output: done is high for one cycle while view_index holds the result of
// one transaction; results come out in start order.
// Pipeline: 3 input and squaring stages, 32 square-root stages (one result
// bit each), one set-up stage, 30 CORDIC stages and 5 scaling, rounding
// and indexing stages. Throughput is one transaction per cycle.
// Configuration: cfg_valid/cfg_ready writes longitude_sectors (index 0),
// latitude_rows (index 1) and hemisphere_only (index 2); other indexes are
// dropped. Write only while no transaction is in flight.
// Reset clears the pipeline valid bits and restores the register defaults
// (8 sectors, 1 row, hemisphere mode). The receiver cannot stall, so the
// pipeline never holds.
`include "assert_macros.svh"

module direction_to_view_bin_index_unit #(
  parameter int MAX_SECTORS = dvbi_pkg::MAX_SECTORS_DEF,
  parameter int MAX_ROWS    = dvbi_pkg::MAX_ROWS_DEF,
  parameter int DIR_BITS    = dvbi_pkg::DIR_BITS_DEF,
  parameter int ANGLE_BITS  = dvbi_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [DIR_BITS-1:0]        dir_x,
  input  logic signed [DIR_BITS-1:0]        dir_y,
  input  logic signed [DIR_BITS-1:0]        dir_z,
  output logic                              done,
  output logic [dvbi_pkg::VIEW_W-1:0]       view_index,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dvbi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dvbi_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int XY_W    = dvbi_pkg::XY_W;
  localparam int ACC_W   = dvbi_pkg::ACC_W;
  localparam int SQ_STEPS = dvbi_pkg::SQRT_STEPS;
  localparam int SQN_W   = dvbi_pkg::SQ_IN_W;
  localparam int GUARD   = 32 - DIR_BITS;
  localparam int SHIFT   = 32 - ANGLE_BITS;
  localparam int SQ_W    = 2 * DIR_BITS;
  localparam int SEC_W   = $clog2(MAX_SECTORS + 1);
  localparam int ROW_W   = $clog2(MAX_ROWS + 1);
  localparam int SP_W    = ANGLE_BITS + SEC_W;
  localparam int LP_W    = ANGLE_BITS + ROW_W + 4;
  localparam int NUM_W   = LP_W + 1;
  localparam int RS_W    = NUM_W - ANGLE_BITS - 1;
  localparam int RC_W    = ROW_W + 1;
  localparam int IDX_W   = RC_W + SEC_W;
  localparam int PROD_W  = (IDX_W > dvbi_pkg::VIEW_W) ? IDX_W : dvbi_pkg::VIEW_W;
  localparam int LATENCY = 3 + SQ_STEPS + 1 + dvbi_pkg::CORDIC_STEPS + 5;

  localparam int SEC_RESET = (dvbi_pkg::SECTORS_RESET > MAX_SECTORS) ? MAX_SECTORS :
                             ((dvbi_pkg::SECTORS_RESET < 1) ? 1 : dvbi_pkg::SECTORS_RESET);
  localparam int ROW_RESET = (dvbi_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS :
                             ((dvbi_pkg::ROWS_RESET < 1) ? 1 : dvbi_pkg::ROWS_RESET);

  // Half an output LSB in Q32 turns; zero when the angle keeps all 32 bits.
  localparam logic signed [ACC_W-1:0] ROUND = (ACC_W'(1) << SHIFT) >>> 1;
  localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(1) << 31;
  localparam logic [SP_W-1:0] HALF_T = SP_W'(1) << (ANGLE_BITS - 1);
  localparam logic signed [NUM_W-1:0] TURN_N = NUM_W'(1) << ANGLE_BITS;
  localparam logic signed [NUM_W-1:0] BIAS_N = (NUM_W'(1) << (ANGLE_BITS + 1)) - NUM_W'(1);

  // ---------------------------------------------------------------- config
  logic [SEC_W-1:0] nsec;
  logic [ROW_W-1:0] nrow;
  logic             hemi;

  always_ff @(posedge clk) begin
    if (rst) begin
      nsec <= SEC_W'(SEC_RESET);
      nrow <= ROW_W'(ROW_RESET);
      hemi <= dvbi_pkg::HEMI_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dvbi_pkg::cfg_reg_t'(cfg_index))
        dvbi_pkg::REG_SECTORS: begin
          if (cfg_data[dvbi_pkg::SECTORS_FIELD_W-1:0] == '0) begin
            nsec <= SEC_W'(1);
          end else if (int'(cfg_data[dvbi_pkg::SECTORS_FIELD_W-1:0]) > MAX_SECTORS) begin
            nsec <= SEC_W'(MAX_SECTORS);
          end else begin
            nsec <= SEC_W'(cfg_data[dvbi_pkg::SECTORS_FIELD_W-1:0]);
          end
        end
        dvbi_pkg::REG_ROWS: begin
          if (cfg_data[dvbi_pkg::ROWS_FIELD_W-1:0] == '0) begin
            nrow <= ROW_W'(1);
          end else if (int'(cfg_data[dvbi_pkg::ROWS_FIELD_W-1:0]) > MAX_ROWS) begin
            nrow <= ROW_W'(MAX_ROWS);
          end else begin
            nrow <= ROW_W'(cfg_data[dvbi_pkg::ROWS_FIELD_W-1:0]);
          end
        end
        dvbi_pkg::REG_HEMI: begin
          hemi <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = !busy;

  // ------------------------------------------------- input and squaring
  logic                       s1_vld;
  logic signed [DIR_BITS-1:0] s1_x, s1_y, s1_z;
  logic                       s2_vld;
  logic signed [DIR_BITS-1:0] s2_x, s2_y, s2_z;
  logic [SQ_W-1:0]            s2_xx, s2_zz;
  logic [DIR_BITS-1:0]        abs_x, abs_z;

  // The most negative component negates to itself, which read unsigned is
  // its magnitude.
  assign abs_x = s1_x[DIR_BITS-1] ? DIR_BITS'(-s1_x) : DIR_BITS'(s1_x);
  assign abs_z = s1_z[DIR_BITS-1] ? DIR_BITS'(-s1_z) : DIR_BITS'(s1_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
      s2_vld <= s1_vld;
    end
    s1_x  <= dir_x;
    s1_y  <= dir_y;
    s1_z  <= dir_z;
    s2_x  <= s1_x;
    s2_y  <= s1_y;
    s2_z  <= s1_z;
    s2_xx <= SQ_W'(abs_x) * SQ_W'(abs_x);
    s2_zz <= SQ_W'(abs_z) * SQ_W'(abs_z);
  end

  // ------------------------------------------------ integer square root
  logic                       sq_vld [SQ_STEPS+1];
  logic [SQN_W-1:0]           sq_n   [SQ_STEPS+1];
  logic [SQN_W-1:0]           sq_res [SQ_STEPS+1];
  logic signed [DIR_BITS-1:0] sq_x   [SQ_STEPS+1];
  logic signed [DIR_BITS-1:0] sq_y   [SQ_STEPS+1];
  logic signed [DIR_BITS-1:0] sq_z   [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= s2_vld;
    end
    sq_n[0]   <= (SQN_W'(s2_xx) + SQN_W'(s2_zz)) << (2 * GUARD);
    sq_res[0] <= '0;
    sq_x[0]   <= s2_x;
    sq_y[0]   <= s2_y;
    sq_z[0]   <= s2_z;
  end

  // Digit-by-digit root: each stage settles one result bit.
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [SQN_W-1:0] ONE_BIT = SQN_W'(1) << (SQN_W - 2 - 2 * i);
    logic [SQN_W-1:0] trial;

    assign trial = sq_res[i] + ONE_BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[i+1] <= 1'b0;
      end else begin
        sq_vld[i+1] <= sq_vld[i];
      end
      if (sq_n[i] >= trial) begin
        sq_n[i+1]   <= sq_n[i] - trial;
        sq_res[i+1] <= (sq_res[i] >> 1) + ONE_BIT;
      end else begin
        sq_n[i+1]   <= sq_n[i];
        sq_res[i+1] <= sq_res[i] >> 1;
      end
      sq_x[i+1] <= sq_x[i];
      sq_y[i+1] <= sq_y[i];
      sq_z[i+1] <= sq_z[i];
    end
  end

  // ----------------------------------------------------- CORDIC set-up
  logic                    pre_vld;
  logic signed [XY_W-1:0]  lon_a, lon_b, lat_a, lat_b;
  logic signed [ACC_W-1:0] lon_acc;
  logic                    lon_zero, all_zero;
  logic signed [XY_W-1:0]  xs_scaled, ys_scaled, zs_scaled;

  assign xs_scaled = XY_W'(sq_x[SQ_STEPS]) <<< GUARD;
  assign ys_scaled = XY_W'(sq_y[SQ_STEPS]) <<< GUARD;
  assign zs_scaled = XY_W'(sq_z[SQ_STEPS]) <<< GUARD;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_vld <= 1'b0;
    end else begin
      pre_vld <= sq_vld[SQ_STEPS];
    end
    // A vector in the left half-plane is turned by half a turn first.
    if (sq_x[SQ_STEPS][DIR_BITS-1]) begin
      lon_a   <= -xs_scaled;
      lon_b   <= -zs_scaled;
      lon_acc <= HALF_TURN;
    end else begin
      lon_a   <= xs_scaled;
      lon_b   <= zs_scaled;
      lon_acc <= '0;
    end
    lat_a    <= $signed(XY_W'(sq_res[SQ_STEPS][dvbi_pkg::HORIZ_W-1:0]));
    lat_b    <= -ys_scaled;
    lon_zero <= (sq_x[SQ_STEPS] == '0) && (sq_z[SQ_STEPS] == '0);
    all_zero <= (sq_x[SQ_STEPS] == '0) && (sq_z[SQ_STEPS] == '0) &&
                (sq_y[SQ_STEPS] == '0);
  end

  logic                    lon_out_vld, lat_out_vld;
  logic signed [ACC_W-1:0] lon_q32, lat_q32;
  logic                    lon_out_zero, lat_out_zero;

  dvbi_cordic #(
    .TAG_W (1)
  ) u_lon_cordic (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (pre_vld),
    .x0          (lon_a),
    .y0          (lon_b),
    .angle0      (lon_acc),
    .tag         (lon_zero),
    .angle_valid (lon_out_vld),
    .angle       (lon_q32),
    .angle_tag   (lon_out_zero)
  );

  dvbi_cordic #(
    .TAG_W (1)
  ) u_lat_cordic (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (pre_vld),
    .x0          (lat_a),
    .y0          (lat_b),
    .angle0      ('0),
    .tag         (all_zero),
    .angle_valid (lat_out_vld),
    .angle       (lat_q32),
    .angle_tag   (lat_out_zero)
  );

  // ------------------------------------------------ angle post-process
  logic                         p1_vld;
  logic [ANGLE_BITS-1:0]        p1_lon;
  logic signed [ANGLE_BITS-1:0] p1_lat;
  logic signed [ACC_W-1:0]      lon_rnd, lat_rnd;

  assign lon_rnd = lon_q32 + ROUND;
  assign lat_rnd = lat_q32 + ROUND;

  // Taking bits 31 down to SHIFT both rounds to the output scale and wraps
  // longitude into one turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= lon_out_vld && lat_out_vld;
    end
    p1_lon <= lon_out_zero ? '0 : lon_rnd[31:SHIFT];
    p1_lat <= lat_out_zero ? '0 : $signed(lat_rnd[31:SHIFT]);
  end

  logic                    p2_vld;
  logic [SP_W-1:0]         p2_sec_prod;
  logic signed [LP_W-1:0]  p2_lat_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
    end
    p2_sec_prod <= SP_W'(p1_lon) * SP_W'(nsec);
    p2_lat_prod <= LP_W'(p1_lat) * $signed(LP_W'({nrow, 3'b000}));
  end

  logic                    p3_vld;
  logic [SEC_W-1:0]        p3_sector;
  logic signed [RS_W-1:0]  p3_row;
  logic [SP_W-1:0]         sec_sum;
  logic [SEC_W-1:0]        sector_raw;
  logic [SEC_W-1:0]        sector_next;
  logic signed [NUM_W-1:0] num, num_biased;

  always_comb begin
    sec_sum    = p2_sec_prod + HALF_T;
    sector_raw = sec_sum[SP_W-1:ANGLE_BITS];
    // A sector that rounds up to the count wraps round to sector zero.
    sector_next = (sector_raw >= nsec) ? '0 : sector_raw;
    num = NUM_W'(p2_lat_prod) + TURN_N;
    // Division by twice a turn, truncating toward zero.
    num_biased = num[NUM_W-1] ? (num + BIAS_N) : num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_vld <= 1'b0;
    end else begin
      p3_vld <= p2_vld;
    end
    p3_sector <= sector_next;
    p3_row    <= $signed(num_biased[NUM_W-1:ANGLE_BITS+1]);
  end

  logic                   p4_vld;
  logic [SEC_W-1:0]       p4_sector;
  logic [RC_W-1:0]        p4_row;
  logic [ROW_W-1:0]       nrow_m1;
  logic signed [RS_W-1:0] row_top, fold;
  logic [RC_W-1:0]        row_next;

  always_comb begin
    nrow_m1  = nrow - ROW_W'(1);
    row_top  = $signed(RS_W'(nrow_m1));
    fold     = -p3_row;
    row_next = RC_W'(p3_row);
    if (p3_row > row_top) begin
      row_next = RC_W'(nrow_m1);
    end else if (p3_row[RS_W-1]) begin
      if (hemi) begin
        row_next = '0;
      end else begin
        // Lower hemisphere rows continue after the upper ones.
        if (fold > row_top) begin
          fold = row_top;
        end
        row_next = RC_W'(nrow_m1) + RC_W'(fold);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_vld <= 1'b0;
    end else begin
      p4_vld <= p3_vld;
    end
    p4_sector <= p3_sector;
    p4_row    <= row_next;
  end

  logic [PROD_W-1:0] index_next;

  assign index_next = PROD_W'(p4_row) * PROD_W'(nsec) + PROD_W'(p4_sector);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p4_vld;
    end
    view_index <= index_next[dvbi_pkg::VIEW_W-1:0];
  end

  // ----------------------------------------------------------- checks
  logic [RC_W-1:0] row_lim;

  assign row_lim = hemi ? RC_W'(nrow) : (RC_W'({nrow, 1'b0}) - RC_W'(1));

  `ASSERT_DELAYED(a_result_latency, start && !busy, LATENCY, done, "transaction produced no result at the pipeline latency")
  `ASSERT_IMPLIES(a_sector_range, p3_vld, p3_sector < nsec, "sector outside the ring")
  `ASSERT_IMPLIES(a_row_range, p4_vld, p4_row < row_lim, "row outside the configured rows")

endmodule
